// ===== src/ckre_pkg.sv =====
// ----------------------------------------------------------------------------
// ckre_pkg
// Shared types, codes and helper functions for the color key run extractor.
// ----------------------------------------------------------------------------
package ckre_pkg;

    localparam int CKRE_MAX_WIDTH     = 4096;
    localparam int CKRE_MAX_HEIGHT    = 4096;
    localparam int CKRE_PALETTE_DEPTH = 256;

    localparam int PIX_W      = 32;
    localparam int PAL_IDX_W  = 8;
    localparam int PAL_DATA_W = 32;
    localparam int KEY_W      = 24;
    localparam int SIZE_CFG_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int RUN_LEFT_W  = 12;
    localparam int RUN_RIGHT_W = 13;
    localparam int RUN_ROW_W   = 12;

    // s_tdata: pixel_value, palette_index, palette_entry
    localparam int S_TDATA_W = 72;
    // m_tdata: run_left, run_right, run_row, zero fill
    localparam int M_TDATA_W = 40;
    localparam int M_FILL_W  = M_TDATA_W - RUN_LEFT_W - RUN_RIGHT_W - RUN_ROW_W;

    localparam logic KIND_PIXEL   = 1'b0;
    localparam logic KIND_PALETTE = 1'b1;

    typedef enum logic [1:0] {
        FMT_PALETTE = 2'd0,
        FMT_RGB565  = 2'd1,
        FMT_RGB24   = 2'd2,
        FMT_RGB32   = 2'd3
    } pix_fmt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_COLOR    = 2'd0,
        REG_PIXEL_FORMAT = 2'd1,
        REG_IMAGE_WIDTH  = 2'd2,
        REG_IMAGE_HEIGHT = 2'd3
    } cfg_reg_t;

    // key is stored as 0x00BBGGRR, pixels are 0x00RRGGBB
    function automatic logic [KEY_W-1:0] key_to_rgb(input logic [KEY_W-1:0] key);
        return {key[7:0], key[15:8], key[23:16]};
    endfunction

    function automatic logic [15:0] key_to_565(input logic [KEY_W-1:0] key);
        // r = key[7:0], g = key[15:8], b = key[23:16]
        return {key[7:3], key[15:10], key[23:19]};
    endfunction

endpackage

// ===== src/ckre_palette.sv =====
// ----------------------------------------------------------------------------
// ckre_palette
// Palette RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ckre_palette
    import ckre_pkg::*;
#(
    parameter int PALETTE_DEPTH = CKRE_PALETTE_DEPTH,
    parameter int ADDR_W        = $clog2(PALETTE_DEPTH)
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [PAL_DATA_W-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output logic [PAL_DATA_W-1:0] rd_data
);

    logic [PAL_DATA_W-1:0] mem [PALETTE_DEPTH];
    logic [PAL_DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/color_key_run_extractor.sv =====
// ----------------------------------------------------------------------------
// color_key_run_extractor
// Compares a raster pixel stream with a key color and emits runs of non-key
// pixels as (left, exclusive right, row) per scan line.
// ----------------------------------------------------------------------------
// Path: stage 1 registers the input and palette read data, then compare and
// run tracking load the output register. Throughput: one item per cycle
// unless m_tready stalls the output; the palette RAM is read and written at
// the input transfer, so a palette write is seen by the very next pixel.
// Reset (aresetn, synchronous, active low) resets position, open run, config
// registers and valid flags; palette contents are undefined until written.
module color_key_run_extractor
    import ckre_pkg::*;
#(
    parameter int MAX_WIDTH     = CKRE_MAX_WIDTH,
    parameter int MAX_HEIGHT    = CKRE_MAX_HEIGHT,
    parameter int PALETTE_DEPTH = CKRE_PALETTE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [31:0] pixel_value, [39:32] palette_index, [71:40] palette_entry
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [0] kind
    input  logic                  s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [11:0] run_left, [24:12] run_right, [36:25] run_row, [39:37] zero
    output logic [M_TDATA_W-1:0]  m_tdata,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WSZ_W  = $clog2(MAX_WIDTH + 1);
    localparam int HSZ_W  = $clog2(MAX_HEIGHT + 1);
    localparam int PAL_AW = $clog2(PALETTE_DEPTH);

    // ------------------------------------------------------------------
    // Input fields
    // ------------------------------------------------------------------
    logic [PIX_W-1:0]      in_pixel;
    logic [PAL_IDX_W-1:0]  in_pal_idx;
    logic [PAL_DATA_W-1:0] in_pal_entry;

    assign in_pixel     = s_tdata[31:0];
    assign in_pal_idx   = s_tdata[39:32];
    assign in_pal_entry = s_tdata[71:40];

    // ------------------------------------------------------------------
    // Configuration (sizes stored already clamped)
    // ------------------------------------------------------------------
    logic [KEY_W-1:0] key_color_reg, key_color_next;
    pix_fmt_t         pix_fmt_reg, pix_fmt_next;
    logic [WSZ_W-1:0] width_reg, width_next;
    logic [HSZ_W-1:0] height_reg, height_next;
    logic [SIZE_CFG_W-1:0] cfg_size;

    assign cfg_ready = 1'b1;
    assign cfg_size  = cfg_data[SIZE_CFG_W-1:0];

    always_comb begin
        key_color_next = key_color_reg;
        pix_fmt_next   = pix_fmt_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_KEY_COLOR: begin
                    key_color_next = cfg_data[KEY_W-1:0];
                end
                REG_PIXEL_FORMAT: begin
                    pix_fmt_next = pix_fmt_t'(cfg_data[1:0]);
                end
                REG_IMAGE_WIDTH: begin
                    if (cfg_size == '0) begin
                        width_next = WSZ_W'(1);
                    end else if (32'(cfg_size) > 32'(MAX_WIDTH)) begin
                        width_next = WSZ_W'(MAX_WIDTH);
                    end else begin
                        width_next = WSZ_W'(cfg_size);
                    end
                end
                REG_IMAGE_HEIGHT: begin
                    if (cfg_size == '0) begin
                        height_next = HSZ_W'(1);
                    end else if (32'(cfg_size) > 32'(MAX_HEIGHT)) begin
                        height_next = HSZ_W'(MAX_HEIGHT);
                    end else begin
                        height_next = HSZ_W'(cfg_size);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_color_reg <= '0;
            pix_fmt_reg   <= FMT_RGB32;
            width_reg     <= WSZ_W'(1);
            height_reg    <= HSZ_W'(1);
        end else begin
            key_color_reg <= key_color_next;
            pix_fmt_reg   <= pix_fmt_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register and palette access
    // ------------------------------------------------------------------
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_kind_reg;
    logic [PIX_W-1:0] s1_pixel_reg;
    logic             s1_pal_ok_reg;
    logic             s1_adv;
    logic             s_accept;
    logic             pal_wr_en;
    logic             pal_rd_en;
    logic [PAL_DATA_W-1:0] pal_rd_data;

    assign s1_adv   = !m_tvalid || m_tready;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_accept = s_tvalid && s_tready;

    assign pal_wr_en = s_accept && (s_tuser == KIND_PALETTE)
                       && (32'(in_pal_idx) < 32'(PALETTE_DEPTH));
    assign pal_rd_en = s_accept && (s_tuser == KIND_PIXEL);

    ckre_palette #(
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .ADDR_W        (PAL_AW)
    ) u_palette (
        .aclk    (aclk),
        .wr_en   (pal_wr_en),
        .wr_addr (in_pal_idx[PAL_AW-1:0]),
        .wr_data (in_pal_entry),
        .rd_en   (pal_rd_en),
        .rd_addr (in_pixel[PAL_AW-1:0]),
        .rd_data (pal_rd_data)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_kind_reg   <= s_tuser;
            s1_pixel_reg  <= in_pixel;
            s1_pal_ok_reg <= 32'(in_pixel[PAL_IDX_W-1:0]) < 32'(PALETTE_DEPTH);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: key compare and run tracking
    // ------------------------------------------------------------------
    logic [KEY_W-1:0]      key_rgb;
    logic [15:0]           key_565;
    logic [PAL_DATA_W-1:0] pal_color;
    logic                  opaque;
    logic                  s1_pix_fire;
    logic                  line_end;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             in_run_reg, in_run_next;
    logic [COL_W-1:0] run_start_reg, run_start_next;

    logic             emit;
    logic [COL_W-1:0] emit_left;
    logic [WSZ_W-1:0] emit_right;
    logic [WSZ_W-1:0] col_plus1;
    logic [HSZ_W-1:0] row_plus1;

    assign key_rgb   = key_to_rgb(key_color_reg);
    assign key_565   = key_to_565(key_color_reg);
    // an index beyond the palette depth reads as zero
    assign pal_color = s1_pal_ok_reg ? pal_rd_data : '0;

    always_comb begin
        case (pix_fmt_reg)
            FMT_PALETTE: opaque = pal_color != PAL_DATA_W'(key_rgb);
            FMT_RGB565:  opaque = s1_pixel_reg[15:0] != key_565;
            FMT_RGB24:   opaque = s1_pixel_reg[23:0] != key_rgb;
            FMT_RGB32:   opaque = s1_pixel_reg != PIX_W'(key_rgb);
            default:     opaque = s1_pixel_reg != PIX_W'(key_rgb);
        endcase
    end

    assign s1_pix_fire = s1_valid_reg && s1_adv && (s1_kind_reg == KIND_PIXEL);
    assign col_plus1   = WSZ_W'(col_reg) + WSZ_W'(1);
    assign row_plus1   = HSZ_W'(row_reg) + HSZ_W'(1);
    assign line_end    = col_plus1 >= width_reg;

    always_comb begin
        col_next       = col_reg;
        row_next       = row_reg;
        in_run_next    = in_run_reg;
        run_start_next = run_start_reg;
        emit           = 1'b0;
        emit_left      = run_start_reg;
        emit_right     = WSZ_W'(col_reg);
        if (s1_pix_fire) begin
            if (in_run_reg) begin
                if (!opaque) begin
                    emit        = 1'b1;
                    in_run_next = 1'b0;
                end
            end else if (opaque) begin
                run_start_next = col_reg;
                in_run_next    = 1'b1;
            end
            if (line_end) begin
                // close a run still open at the last pixel of the line
                if (in_run_next) begin
                    emit        = 1'b1;
                    emit_left   = run_start_next;
                    emit_right  = col_plus1;
                    in_run_next = 1'b0;
                end
                col_next = '0;
                if (row_plus1 >= height_reg) begin
                    row_next = '0;
                end else begin
                    row_next = ROW_W'(row_plus1);
                end
            end else begin
                col_next = COL_W'(col_plus1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            in_run_reg    <= 1'b0;
            run_start_reg <= '0;
        end else begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            in_run_reg    <= in_run_next;
            run_start_reg <= run_start_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic                   m_valid_reg, m_valid_next;
    logic [RUN_LEFT_W-1:0]  run_left_reg;
    logic [RUN_RIGHT_W-1:0] run_right_reg;
    logic [RUN_ROW_W-1:0]   run_row_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            run_left_reg  <= RUN_LEFT_W'(emit_left);
            run_right_reg <= RUN_RIGHT_W'(emit_right);
            run_row_reg   <= RUN_ROW_W'(row_reg);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_FILL_W{1'b0}}, run_row_reg, run_right_reg, run_left_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_run_start_behind_col: assert property (@(posedge aclk) disable iff (!aresetn)
        in_run_reg |-> (run_start_reg < col_reg))
        else $error("open run does not start left of the current column");

    a_line_end_closes_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_pix_fire && line_end) |=> (!in_run_reg && (col_reg == '0)))
        else $error("run or column not cleared at line end");

    a_result_needs_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_adv && !s1_pix_fire) |=> !m_valid_reg)
        else $error("result appeared without a pixel transfer");

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_pixel_reg)))
        else $error("stalled stage 1 item lost");

    a_no_accept_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_adv) |-> !s_tready)
        else $error("input taken while stage 1 is stalled");

endmodule
